// ===== rtl/core/tstm_pkg.sv =====
// Shared types, constants and helpers of the two-node thermal model monitor.
`timescale 1ns / 1ps
package tstm_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_R1  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_C1  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_R2  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_C2  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_THR = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMB = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DT  = 3'd6;

   localparam logic [31:0]        R1_RESET  = 32'd13509;
   localparam logic [31:0]        C1_RESET  = 32'd3297371;
   localparam logic [31:0]        R2_RESET  = 32'd1417048;
   localparam logic [31:0]        C2_RESET  = 32'd1041654;
   localparam logic [14:0]        THR_RESET = 15'd1280;
   localparam logic signed [15:0] AMB_RESET = 16'sd3200;
   localparam logic [15:0]        DT_RESET  = 16'd256;

   // model node state, signed Q16.16
   localparam logic signed [31:0] T1_RESET = 32'sd3932160;
   localparam logic signed [31:0] T2_RESET = 32'sd1966080;

   // divider: 88-bit dividend, quotient clamped to 2^40
   localparam int DIV_STEPS = 88;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int QUOT_W    = 41;
   localparam logic [QUOT_W-1:0] DELTA_CAP = 41'h100_0000_0000;

   typedef struct packed {
      logic signed [15:0] load_current;
      logic signed [15:0] measured_temp;
   } req_type;

   typedef struct packed {
      logic signed [15:0] inner_model_temp;
      logic signed [15:0] outer_model_temp;
      logic               deviation_alert;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        stage_one_resistance;
      logic [31:0]        stage_one_capacitance;
      logic [31:0]        stage_two_resistance;
      logic [31:0]        stage_two_capacitance;
      logic [14:0]        alert_threshold;
      logic signed [15:0] ambient_temp;
      logic [15:0]        time_step;
   } cfg_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Q16.16 node value to 1/128 degC: floor divide by 512, then saturate
   function automatic logic signed [15:0] to_out(input logic signed [31:0] t);
      logic signed [22:0] sh;
      logic signed [15:0] r;
      sh = t[31:9];
      if (sh > 23'sd32767) begin
         r = 16'sh7fff;
      end else if (sh < -23'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = sh[15:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/two_stage_thermal_model_monitor.sv =====
// Top level: sequencer of the two-node RC thermal model and deviation monitor.
`timescale 1ns / 1ps
// Usage
//   Request channel (req_valid/req_ready/req_payload) carries one sample:
//   load current and measured temperature. Response channel
//   (rsp_valid/rsp_ready/rsp_payload) returns both updated node temperatures
//   and the deviation alert, one response per request, in order.
//   csr_wr_en/csr_index/csr_wdata write the seven model registers; write
//   them only while no request is in flight.
//   A new request is accepted only once the sequencer is back in idle,
//   so the block works on one request at a time. The bit-serial divider
//   runs once per node update (88 quotient bits), twice per request, and
//   the shared 32x32 multiplier forms I^2, R1*I^2, num*dt and R*C.
//   Reset (synchronous, active high) loads the register defaults and sets
//   the nodes to 60.0 and 30.0 degC.
//   A stalled receiver holds the response in the output register; a new
//   request is still accepted, and its result waits in the last step until
//   the output register is free.
module two_stage_thermal_model_monitor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tstm_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tstm_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [tstm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tstm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tstm_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_SQ    = 11'b000_0000_0010,
      ST_HEAT  = 11'b000_0000_0100,
      ST_NUM   = 11'b000_0000_1000,
      ST_MLO   = 11'b000_0001_0000,
      ST_MHI   = 11'b000_0010_0000,
      ST_RC    = 11'b000_0100_0000,
      ST_DLOAD = 11'b000_1000_0000,
      ST_DIV   = 11'b001_0000_0000,
      ST_UPD   = 11'b010_0000_0000,
      ST_OUT   = 11'b100_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic               stage_ff, stage_in;
   logic [15:0]        cur_mag_ff, cur_mag_in;
   logic signed [15:0] meas_ff, meas_in;
   logic [47:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [63:0]        acc_ff, acc_in;
   logic signed [31:0] t1_ff, t1_in;
   logic signed [31:0] t2_ff, t2_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   cfg_type            cfg;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        prod;
   div_ctl_type        div_ctl;
   div_stat_type       div_stat;
   logic [63:0]        divisor;
   logic [QUOT_W-1:0]  quotient;

   logic [15:0]        cur_abs;
   logic [49:0]        heat_x, amb_x, t1_x, t2_x;
   logic [49:0]        num1, num2, num, num_abs;
   logic [QUOT_W:0]    dq, delta;
   logic [42:0]        node_x, sum;
   logic signed [31:0] node_sat;
   logic [33:0]        meas_x, t2_34, diff, diff_abs, thr_x;
   logic               alert;

   tstm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tstm_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   tstm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (acc_ff),
      .divisor  (divisor),
      .stat     (div_stat),
      .quotient (quotient)
   );

   // magnitude of the load current; the most negative code maps to 32768
   assign cur_abs = req_payload.load_current[15] ?
                    (~req_payload.load_current + 16'd1) : req_payload.load_current;

   // numerators of the two Euler steps, Q16.16
   always_comb begin
      heat_x  = {2'b0, prod[63:16]};
      amb_x   = {{25{cfg.ambient_temp[15]}}, cfg.ambient_temp, 9'b0};
      t1_x    = {{18{t1_ff[31]}}, t1_ff};
      t2_x    = {{18{t2_ff[31]}}, t2_ff};
      num1    = heat_x + amb_x - t1_x;
      num2    = t1_x - t2_x;
      num     = stage_ff ? num2 : num1;
      num_abs = num[49] ? (~num + 50'd1) : num;
   end

   // apply the signed step to the node and saturate to 32 bits
   always_comb begin
      dq     = {1'b0, quotient};
      delta  = neg_ff ? (~dq + 42'd1) : dq;
      node_x = stage_ff ? {{11{t2_ff[31]}}, t2_ff} : {{11{t1_ff[31]}}, t1_ff};
      sum    = node_x + {delta[QUOT_W], delta};
      if (!sum[42] && (sum[41:31] != 11'd0)) begin
         node_sat = 32'sh7fff_ffff;
      end else if (sum[42] && (sum[41:31] != 11'h7ff)) begin
         node_sat = 32'sh8000_0000;
      end else begin
         node_sat = sum[31:0];
      end
   end

   // deviation of the measurement from the outer node
   always_comb begin
      meas_x   = {{9{meas_ff[15]}}, meas_ff, 9'b0};
      t2_34    = {{2{t2_ff[31]}}, t2_ff};
      diff     = meas_x - t2_34;
      diff_abs = diff[33] ? (~diff + 34'd1) : diff;
      thr_x    = {10'b0, cfg.alert_threshold, 9'b0};
      alert    = diff_abs > thr_x;
   end

   // steer the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ: begin
            mul_a = {16'b0, cur_mag_ff};
            mul_b = {16'b0, cur_mag_ff};
         end
         ST_HEAT: begin
            mul_a = cfg.stage_one_resistance;
            mul_b = prod[31:0];
         end
         ST_MLO: begin
            mul_a = mag_ff[31:0];
            mul_b = {16'b0, cfg.time_step};
         end
         ST_MHI: begin
            mul_a = {16'b0, mag_ff[47:32]};
            mul_b = {16'b0, cfg.time_step};
         end
         ST_RC: begin
            mul_a = stage_ff ? cfg.stage_two_resistance : cfg.stage_one_resistance;
            mul_b = stage_ff ? cfg.stage_two_capacitance : cfg.stage_one_capacitance;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // a zero R*C divides as one
   assign divisor       = (prod == 64'd0) ? 64'd1 : prod;
   assign div_ctl.start = (state_ff == ST_DLOAD);
   assign req_ready     = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      cur_mag_in   = cur_mag_ff;
      meas_in      = meas_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_mag_in = cur_abs;
               meas_in    = req_payload.measured_temp;
               stage_in   = 1'b0;
               state_in   = ST_SQ;
            end
         end
         ST_SQ:   state_in = ST_HEAT;
         ST_HEAT: state_in = ST_NUM;
         ST_NUM: begin
            mag_in   = num_abs[47:0];
            neg_in   = num[49];
            state_in = ST_MLO;
         end
         ST_MLO:  state_in = ST_MHI;
         ST_MHI: begin
            acc_in   = prod;
            state_in = ST_RC;
         end
         ST_RC: begin
            acc_in   = acc_ff + {prod[31:0], 32'b0};
            state_in = ST_DLOAD;
         end
         ST_DLOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (stage_ff) begin
               t2_in    = node_sat;
               state_in = ST_OUT;
            end else begin
               t1_in    = node_sat;
               stage_in = 1'b1;
               state_in = ST_NUM;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.inner_model_temp = to_out(t1_ff);
               rsp_in.outer_model_temp = to_out(t2_ff);
               rsp_in.deviation_alert  = alert;
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         t1_ff        <= T1_RESET;
         t2_ff        <= T2_RESET;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
         t1_ff        <= t1_in;
         t2_ff        <= t2_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_mag_ff <= cur_mag_in;
      meas_ff    <= meas_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      acc_ff     <= acc_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // the divider only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide step");

   // a node update never reads a quotient that is still changing
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> !div_stat.busy)
      else $error("node update while divider busy");

   // an accepted request closes the request channel until it completes
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted twice back to back");

endmodule

// ===== rtl/core/tstm_csr.sv =====
// Configuration register file of the thermal model monitor.
`timescale 1ns / 1ps
module tstm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [tstm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tstm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output tstm_pkg::cfg_type                    cfg
);
   import tstm_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // decode the write, mask to the register width, drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_R1:  cfg_in.stage_one_resistance  = csr_wdata;
            CSR_C1:  cfg_in.stage_one_capacitance = csr_wdata;
            CSR_R2:  cfg_in.stage_two_resistance  = csr_wdata;
            CSR_C2:  cfg_in.stage_two_capacitance = csr_wdata;
            CSR_THR: cfg_in.alert_threshold       = csr_wdata[14:0];
            CSR_AMB: cfg_in.ambient_temp          = csr_wdata[15:0];
            CSR_DT:  cfg_in.time_step             = csr_wdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stage_one_resistance  <= R1_RESET;
         cfg_ff.stage_one_capacitance <= C1_RESET;
         cfg_ff.stage_two_resistance  <= R2_RESET;
         cfg_ff.stage_two_capacitance <= C2_RESET;
         cfg_ff.alert_threshold       <= THR_RESET;
         cfg_ff.ambient_temp          <= AMB_RESET;
         cfg_ff.time_step             <= DT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/tstm_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps
module tstm_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] prod
);
   logic [63:0] prod_ff;

   // register the product for the next sequencer step
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/tstm_div.sv =====
// Bit-serial restoring divider with the quotient clamped to 2^40.
`timescale 1ns / 1ps
module tstm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  tstm_pkg::div_ctl_type        ctl,
   input  logic [63:0]                  dividend,
   input  logic [63:0]                  divisor,
   output tstm_pkg::div_stat_type       stat,
   output logic [tstm_pkg::QUOT_W-1:0]  quotient
);
   import tstm_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_STEPS-1:0]     num_ff, num_in;
   logic [63:0]              d_ff, d_in;
   logic [63:0]              rem_ff, rem_in;
   logic [QUOT_W-1:0]        q_ff, q_in;
   logic                     sat_ff, sat_in;

   logic [64:0]              rem_sh;
   logic [64:0]              rem_sub;
   logic                     ge;
   logic [QUOT_W:0]          q_sh;
   logic                     sat_nx;

   // one quotient bit: shift in the next dividend bit, trial subtract
   always_comb begin
      rem_sh  = {rem_ff, num_ff[DIV_STEPS-1]};
      rem_sub = rem_sh - {1'b0, d_ff};
      ge      = (rem_sh >= {1'b0, d_ff});
      q_sh    = {q_ff, ge};
      sat_nx  = sat_ff | (q_sh > {1'b0, DELTA_CAP});
   end

   // sequence load, iterate, finish
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         num_in  = {dividend, 24'b0};
         d_in    = divisor;
         rem_in  = '0;
         q_in    = '0;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_STEPS-2:0], 1'b0};
         rem_in = ge ? rem_sub[63:0] : rem_sh[63:0];
         sat_in = sat_nx;
         q_in   = sat_nx ? DELTA_CAP : q_sh[QUOT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;

   // a new division never starts over a running one
   assert property (@(posedge clock) disable iff (reset) ctl.start |-> !busy_ff)
      else $error("divider started while busy");

   // done follows the last iteration and the unit is idle then
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && $past(busy_ff)))
      else $error("divider done without a finished run");

   // the clamp keeps the quotient at or below the cap
   assert property (@(posedge clock) disable iff (reset) done_ff |-> (q_ff <= DELTA_CAP))
      else $error("quotient above clamp");

endmodule

// ===== verif/tstm_node_checker.sv =====
// Checker for the thermal model monitor: mirrors registers, predicts node temperatures, compares.
`timescale 1ns / 1ps
module tstm_node_checker
   import tstm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   localparam longint NODE_HI = 64'sd2147483647;
   localparam longint NODE_LO = -64'sd2147483648;

   cfg_type cfg_mirror;
   longint  inner_q16;
   longint  outer_q16;
   rsp_type predicted_temps[$];
   int      mismatches = 0;

   // clamp a node value to the signed Q16.16 range
   function automatic longint clamp_node(input longint v);
      if (v > NODE_HI) begin
         return NODE_HI;
      end else if (v < NODE_LO) begin
         return NODE_LO;
      end
      return v;
   endfunction

   // num * dt * 2^24 / (r * c), truncated toward zero, magnitude capped at 2^40
   function automatic longint euler_step(input longint num, input logic [31:0] r,
                                         input logic [31:0] c, input logic [15:0] dt);
      logic [63:0]  divisor;
      logic [63:0]  mag;
      logic [127:0] quot;
      divisor = {32'd0, r} * {32'd0, c};
      // a zero product falls back to the smallest divisor
      if (divisor == 64'd0) begin
         divisor = 64'd1;
      end
      mag = (num < 0) ? 64'(-num) : 64'(num);
      quot = ({64'd0, mag * {48'd0, dt}} << 24) / {64'd0, divisor};
      if (quot > 128'(DELTA_CAP)) begin
         quot = 128'(DELTA_CAP);
      end
      return (num < 0) ? -longint'(quot[63:0]) : longint'(quot[63:0]);
   endfunction

   // Q16.16 to 1/128 degC: floor, then saturate to 16 bits
   function automatic logic signed [15:0] node_to_field(input longint t);
      longint v;
      v = t >>> 9;
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      return v[15:0];
   endfunction

   // advance both nodes by one Euler step and judge the measured deviation
   function automatic rsp_type advance_nodes(input req_type s);
      longint      amps;
      longint      meas;
      longint      heat;
      longint      num;
      longint      diff;
      logic [63:0] amps_sq;
      rsp_type     r;
      amps    = longint'($signed(s.load_current));
      meas    = longint'($signed(s.measured_temp));
      amps_sq = 64'(amps * amps);
      heat    = longint'(({32'd0, cfg_mirror.stage_one_resistance} * amps_sq) >> 16);
      num = heat + longint'($signed(cfg_mirror.ambient_temp)) * 512 - inner_q16;
      inner_q16 = clamp_node(inner_q16 + euler_step(num, cfg_mirror.stage_one_resistance,
                             cfg_mirror.stage_one_capacitance, cfg_mirror.time_step));
      num = inner_q16 - outer_q16;
      outer_q16 = clamp_node(outer_q16 + euler_step(num, cfg_mirror.stage_two_resistance,
                             cfg_mirror.stage_two_capacitance, cfg_mirror.time_step));
      diff = meas * 512 - outer_q16;
      if (diff < 0) begin
         diff = -diff;
      end
      r.inner_model_temp = node_to_field(inner_q16);
      r.outer_model_temp = node_to_field(outer_q16);
      r.deviation_alert  = (diff > longint'(cfg_mirror.alert_threshold) * 512);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         cfg_mirror = {R1_RESET, C1_RESET, R2_RESET, C2_RESET, THR_RESET, AMB_RESET, DT_RESET};
         inner_q16  = longint'(T1_RESET);
         outer_q16  = longint'(T2_RESET);
         predicted_temps.delete();
      end else begin
         // mirror register writes, masked to each register's width
         if (csr_wr_en) begin
            case (csr_index)
               CSR_R1:  cfg_mirror.stage_one_resistance  = csr_wdata;
               CSR_C1:  cfg_mirror.stage_one_capacitance = csr_wdata;
               CSR_R2:  cfg_mirror.stage_two_resistance  = csr_wdata;
               CSR_C2:  cfg_mirror.stage_two_capacitance = csr_wdata;
               CSR_THR: cfg_mirror.alert_threshold       = csr_wdata[14:0];
               CSR_AMB: cfg_mirror.ambient_temp          = csr_wdata[15:0];
               CSR_DT:  cfg_mirror.time_step             = csr_wdata[15:0];
               default: ;  // drop writes to unmapped indexes
            endcase
         end
         if (req_valid && req_ready) begin
            predicted_temps.push_back(advance_nodes(req_payload));
         end
         // compare each response with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (predicted_temps.size() == 0) begin
               $error("response with no request outstanding: %p", got);
               mismatches++;
            end else begin
               want = predicted_temps.pop_front();
               if (got.inner_model_temp !== want.inner_model_temp) begin
                  $error("inner_model_temp: expected %0d, got %0d",
                         want.inner_model_temp, got.inner_model_temp);
                  mismatches++;
               end
               if (got.outer_model_temp !== want.outer_model_temp) begin
                  $error("outer_model_temp: expected %0d, got %0d",
                         want.outer_model_temp, got.outer_model_temp);
                  mismatches++;
               end
               if (got.deviation_alert !== want.deviation_alert) begin
                  $error("deviation_alert: expected %0d, got %0d",
                         want.deviation_alert, got.deviation_alert);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= predicted_temps.size();
   end

endmodule

// ===== verif/two_stage_thermal_model_monitor_tb.sv =====
// Testbench top for the thermal model monitor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module two_stage_thermal_model_monitor_tb;
   import tstm_pkg::*;

   localparam int SAMPLES_PER_PHASE = 210;
   localparam int HOLD_OFF_CYCLES   = 2000;
   localparam int QUIET_LIMIT       = 12000;
   localparam int DRAIN_CYCLES      = 400;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   req_type                req_payload = '0;
   logic                   rsp_ready   = 1'b0;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;
   logic                   req_ready;
   logic                   rsp_valid;
   rsp_type                rsp_payload;
   int                     fail_count;
   int                     pending;

   logic               steady       = 1'b0;
   logic               hold_off_req = 1'b0;
   cfg_type            active_cfg;
   logic signed [15:0] last_outer   = 16'sd3840;
   int                 quiet_cycles = 0;

   always #6 clock = ~clock;

   two_stage_thermal_model_monitor dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   tstm_node_checker node_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // track the latest outer node temperature; stop the run when nothing moves
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         last_outer <= rsp_payload.outer_model_temp;
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 36);
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // drop valid and wait until every request has its response
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic load_settings(input cfg_type c);
      wait_idle();
      write_reg(CSR_R1, c.stage_one_resistance);
      write_reg(CSR_C1, c.stage_one_capacitance);
      write_reg(CSR_R2, c.stage_two_resistance);
      write_reg(CSR_C2, c.stage_two_capacitance);
      write_reg(CSR_THR, {17'd0, c.alert_threshold});
      write_reg(CSR_AMB, {16'd0, c.ambient_temp});
      write_reg(CSR_DT, {16'd0, c.time_step});
      csr_wr_en <= 1'b0;
      active_cfg = c;
   endtask

   // offer one request, idling first at random, and hold it until accepted
   task automatic push_sample(input logic signed [15:0] amps, input logic signed [15:0] temp);
      while (!steady && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{load_current: amps, measured_temp: temp};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // mostly moderate currents; measured temperature often near the outer node
   task automatic push_random();
      int amps;
      int span;
      int guess;
      if ($urandom_range(99) < 25) begin
         amps = int'($urandom_range(65535)) - 32768;
      end else begin
         amps = int'($urandom_range(8191)) - 4096;
      end
      if ($urandom_range(99) < 55) begin
         span  = int'(active_cfg.alert_threshold) + 256;
         guess = int'(last_outer) + int'($urandom_range(2 * span)) - span;
         if (guess > 32767) begin
            guess = 32767;
         end else if (guess < -32768) begin
            guess = -32768;
         end
      end else begin
         guess = int'($urandom_range(65535)) - 32768;
      end
      push_sample(16'(amps), 16'(guess));
   endtask

   function automatic logic [31:0] pick_rc();
      int sel;
      sel = $urandom_range(99);
      if (sel < 30) begin
         return $urandom();
      end else if (sel < 60) begin
         return $urandom_range(32'd1 << 20, 1);
      end
      return $urandom_range(32'd1 << 24, 32'd1 << 12);
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.stage_one_resistance  = pick_rc();
      c.stage_one_capacitance = pick_rc();
      c.stage_two_resistance  = pick_rc();
      c.stage_two_capacitance = pick_rc();
      c.alert_threshold = ($urandom_range(99) < 50) ? 15'($urandom_range(2048))
                                                    : 15'($urandom_range(32767));
      c.ambient_temp    = 16'($urandom());
      c.time_step       = ($urandom_range(99) < 50) ? 16'($urandom_range(1024, 1))
                                                    : 16'($urandom_range(65535, 1));
      return c;
   endfunction

   initial begin
      cfg_type defaults;
      cfg_type corner;
      int      ph;
      defaults   = {R1_RESET, C1_RESET, R2_RESET, C2_RESET, THR_RESET, AMB_RESET, DT_RESET};
      active_cfg = defaults;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero time step: nodes hold at 60 and 30 degC, probe the alert edges
      write_reg(CSR_DT, 32'd0);
      csr_wr_en <= 1'b0;
      push_sample(16'sh7fff, 16'sd5120);
      push_sample(16'sh8000, 16'sd5121);
      push_sample(16'sd0, 16'sd2560);
      push_sample(16'sd0, 16'sd2559);
      push_sample(16'sh8000, 16'sh8000);
      push_sample(16'sh7fff, 16'sh7fff);

      // restore defaults through an unmapped index and oversized data
      wait_idle();
      write_reg(CSR_UNMAPPED, 32'hDEAD_BEEF);
      write_reg(CSR_THR, 32'hFFFF_0500);
      write_reg(CSR_AMB, 32'hABCD_0C80);
      write_reg(CSR_DT, 32'hFFFF_0100);
      csr_wr_en <= 1'b0;

      // field extremes at the default settings
      push_sample(16'sd0, 16'sd0);
      push_sample(16'sh7fff, 16'sh7fff);
      push_sample(16'sh8000, 16'sh8000);
      push_sample(16'sd256, 16'sd3840);
      push_sample(-16'sd256, 16'sd7680);
      push_sample(16'sh7fff, 16'sh8000);
      push_sample(16'sh8000, 16'sh7fff);
      push_sample(16'sd1, -16'sd1);
      push_sample(-16'sd1, 16'sd1);

      // zero resistance and capacitance: step divisor falls back to one
      corner = defaults;
      corner.stage_one_resistance  = 32'd0;
      corner.stage_two_capacitance = 32'd0;
      load_settings(corner);
      push_sample(16'sh7fff, 16'sd0);
      push_sample(16'sh8000, 16'sh7fff);
      push_sample(16'sd0, 16'sh8000);
      push_sample(16'sd100, 16'sd100);

      // random requests over defaults, both extremes and random settings
      for (ph = 0; ph < 8; ph++) begin
         if (ph == 0) begin
            load_settings(defaults);
         end else if (ph == 1) begin
            load_settings({{4{32'hFFFF_FFFF}}, 15'h7fff, 16'sh7fff, 16'hFFFF});
         end else if (ph == 2) begin
            load_settings({{4{32'd1}}, 15'd0, 16'sh8000, 16'd1});
         end else begin
            load_settings(random_settings());
         end
         steady <= (ph == 3);
         for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
            if (ph == 0 && n == 20) begin
               hold_off_req <= 1'b1;
            end
            push_random();
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tstm_pkg.sv
rtl/core/tstm_csr.sv
rtl/core/tstm_mul.sv
rtl/core/tstm_div.sv
rtl/core/two_stage_thermal_model_monitor.sv
verif/tstm_node_checker.sv
verif/two_stage_thermal_model_monitor_tb.sv
